@@ hw/rtl/tricubic_catmull_rom_sampler_assert.svh @@
// ----------------------------------------------------------------------------
// Tricubic sampler assertion macros
// Shared concurrent assertion forms for the sampler checker.
// ----------------------------------------------------------------------------
`ifndef TRICUBIC_CATMULL_ROM_SAMPLER_ASSERT_SVH
`define TRICUBIC_CATMULL_ROM_SAMPLER_ASSERT_SVH

// same-cycle implication, masked during reset
`define TCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define TCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define TCR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tcr_pkg.sv @@
// ----------------------------------------------------------------------------
// Tricubic sampler package
// Shared constants, codes and controller/datapath link types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tcr_pkg;

  localparam int DEF_MAX_DIM      = 32;
  localparam int DEF_SAMPLE_WIDTH = 32;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int CELL_W     = 5;
  localparam int POINT_W    = 32;
  localparam int SIZE_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TAP_W      = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SP   = 3'd6;

  typedef struct packed {
    logic             capture;
    logic             mem_wr;
    logic             split_issue;
    logic [1:0]       axis;
    logic             sq;
    logic             cube;
    logic             wgt;
    logic             tap_issue;
    logic [TAP_W-1:0] tap;
    logic             res_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/tcr_req_if.sv @@
// ----------------------------------------------------------------------------
// Tricubic sampler request channel
// Valid/ready channels: one write or query word in, one interpolated result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tcr_req_if import tcr_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [CELL_W-1:0]              cell_x;
  logic [CELL_W-1:0]              cell_y;
  logic [CELL_W-1:0]              cell_z;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;
  logic signed [POINT_W-1:0]      point_x;
  logic signed [POINT_W-1:0]      point_y;
  logic signed [POINT_W-1:0]      point_z;

  modport source (output valid, operation, cell_x, cell_y, cell_z, sample_value,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, operation, cell_x, cell_y, cell_z, sample_value,
                point_x, point_y, point_z, output ready);
endinterface

interface tcr_rsp_if import tcr_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] interp_value;
  logic                           saturated;

  modport source (output valid, interp_value, saturated, input ready);
  modport sink (input valid, interp_value, saturated, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tcr_datapath.sv @@
// ----------------------------------------------------------------------------
// Tricubic sampler datapath
// Config registers, grid memory, axis split, weights and tap accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tcr_datapath import tcr_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic [CELL_W-1:0]              cell_x,
  input  logic [CELL_W-1:0]              cell_y,
  input  logic [CELL_W-1:0]              cell_z,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
  input  logic signed [POINT_W-1:0]      point_x,
  input  logic signed [POINT_W-1:0]      point_y,
  input  logic signed [POINT_W-1:0]      point_z,
  input  cmd_t                           cmd,
  output sts_t                           sts,
  output logic signed [SAMPLE_WIDTH-1:0] interp_value,
  output logic                           saturated
);
  localparam int F         = FRAC_BITS;
  localparam int IW        = $clog2(MAX_DIM);
  localparam int DEPTH     = 1 << (3 * IW);
  localparam int CW        = $clog2(MAX_DIM + 5) + 1;
  localparam int PW        = 64;
  localparam int TW        = PW - F + 1;
  localparam int MW        = TW - F + 1;
  localparam int NW        = F + 5;
  localparam int WW        = F + 3;
  localparam int AW        = SAMPLE_WIDTH + 8;
  localparam int TRW       = WW + SAMPLE_WIDTH - F;
  localparam logic [PW-2*F-1:0] CELL_HI = (PW-2*F)'(MAX_DIM + 4);
  localparam logic [MW-1:0]     CELL_LO = MW'(4);
  localparam logic signed [NW-1:0] K2  = NW'(2);
  localparam logic signed [NW-1:0] K3  = NW'(3);
  localparam logic signed [NW-1:0] K4  = NW'(4);
  localparam logic signed [NW-1:0] K5  = NW'(5);
  localparam logic signed [NW-1:0] ONE = NW'(1) <<< F;
  localparam logic signed [AW-1:0] SAT_HI = AW'((64'(1) << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

  // configuration
  logic [SIZE_W-1:0]  size_x, size_y, size_z;
  logic [POINT_W-1:0] origin_x, origin_y, origin_z;
  logic [31:0]        inv_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= SIZE_W'(32);
      size_y      <= SIZE_W'(32);
      size_z      <= SIZE_W'(32);
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      inv_spacing <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_X:   size_x      <= cfg_data[SIZE_W-1:0];
        CFG_GRID_Y:   size_y      <= cfg_data[SIZE_W-1:0];
        CFG_GRID_Z:   size_z      <= cfg_data[SIZE_W-1:0];
        CFG_ORIGIN_X: origin_x    <= cfg_data;
        CFG_ORIGIN_Y: origin_y    <= cfg_data;
        CFG_ORIGIN_Z: origin_z    <= cfg_data;
        CFG_INV_SP:   inv_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // query capture
  logic [POINT_W-1:0] pt_x, pt_y, pt_z;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pt_x <= point_x;
      pt_y <= point_y;
      pt_z <= point_z;
    end
  end

  // axis split: multiply stage
  logic [POINT_W-1:0] sel_p, sel_o;
  logic signed [POINT_W:0] rel;
  logic [POINT_W:0]   mag;
  logic [PW:0]        prod_full;
  logic [PW-1:0]      prod_q;
  logic               neg_q, sv_q;
  logic [1:0]         sax_q;

  always_comb begin
    case (cmd.axis)
      2'd0:    begin sel_p = pt_x; sel_o = origin_x; end
      2'd1:    begin sel_p = pt_y; sel_o = origin_y; end
      default: begin sel_p = pt_z; sel_o = origin_z; end
    endcase
    rel       = $signed({sel_p[POINT_W-1], sel_p}) - $signed({sel_o[POINT_W-1], sel_o});
    mag       = rel[POINT_W] ? (POINT_W+1)'(-rel) : (POINT_W+1)'(rel);
    prod_full = (PW+1)'(mag) * (PW+1)'(inv_spacing);
  end

  always_ff @(posedge clk) begin
    if (rst) sv_q <= 1'b0;
    else     sv_q <= cmd.split_issue;
    prod_q <= prod_full[PW-1:0];
    neg_q  <= rel[POINT_W];
    sax_q  <= cmd.axis;
  end

  // axis split: floor cell and fraction
  logic [PW-2*F-1:0]     cm_pos;
  logic [TW-1:0]         t_neg;
  logic [MW-1:0]         cm_neg;
  logic signed [CW-1:0]  cpos_n;
  logic [F-1:0]          frac_n;
  logic signed [CW-1:0]  cpos_r [3];
  logic [F-1:0]          frac_r [3];

  always_comb begin
    cm_pos = prod_q[PW-1:2*F];
    t_neg  = TW'(prod_q[PW-1:F]) + TW'(|prod_q[F-1:0]);
    cm_neg = MW'(t_neg[TW-1:F]) + MW'(|t_neg[F-1:0]);
    if (!neg_q) begin
      cpos_n = (cm_pos > CELL_HI) ? CW'(CELL_HI) : CW'(cm_pos);
      frac_n = prod_q[2*F-1:F];
    end else begin
      cpos_n = -((cm_neg > CELL_LO) ? CW'(CELL_LO) : CW'(cm_neg));
      frac_n = -t_neg[F-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (sv_q) begin
      cpos_r[sax_q] <= cpos_n;
      frac_r[sax_q] <= frac_n;
    end
  end

  // weights, one axis at a time
  logic [F-1:0]          u, u2, u3;
  logic [2*F-1:0]        sq_p, cu_p;
  logic signed [NW-1:0]  su, s2, s3, n0, n1, n2, n3;
  logic signed [WW-1:0]  wx [4];
  logic signed [WW-1:0]  wy [4];
  logic signed [WW-1:0]  wz [4];
  logic signed [WW-1:0]  wn [4];

  always_comb begin
    u    = frac_r[cmd.axis];
    sq_p = (2*F)'(u) * (2*F)'(u);
    cu_p = (2*F)'(u2) * (2*F)'(u);
    su   = $signed(NW'(u));
    s2   = $signed(NW'(u2));
    s3   = $signed(NW'(u3));
    n0   = -s3 + K2 * s2 - su;
    n1   = K3 * s3 - K5 * s2 + K2 * ONE;
    n2   = -K3 * s3 + K4 * s2 + su;
    n3   = s3 - s2;
    wn[0] = WW'(n0 >>> 1);
    wn[1] = WW'(n1 >>> 1);
    wn[2] = WW'(n2 >>> 1);
    wn[3] = WW'(n3 >>> 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.sq)   u2 <= sq_p[2*F-1:F];
    if (cmd.cube) u3 <= cu_p[2*F-1:F];
    if (cmd.wgt) begin
      case (cmd.axis)
        2'd0:    wx <= wn;
        2'd1:    wy <= wn;
        default: wz <= wn;
      endcase
    end
  end

  // tap index clamp
  function automatic logic [IW-1:0] clamp_tap(input logic signed [CW-1:0] c,
                                              input logic [1:0] off,
                                              input logic [SIZE_W-1:0] sz);
    logic signed [CW:0] t;
    logic signed [CW:0] n;
    begin
      t = $signed({c[CW-1], c}) + $signed((CW+1)'(off)) - (CW+1)'(1);
      if (sz == '0)                 n = (CW+1)'(1);
      else if (int'(sz) > MAX_DIM) n = (CW+1)'(MAX_DIM);
      else                          n = (CW+1)'(sz);
      if (t < 0)       clamp_tap = '0;
      else if (t >= n) clamp_tap = IW'(n - (CW+1)'(1));
      else             clamp_tap = IW'(t);
    end
  endfunction

  logic [1:0]            ta, tb, tc;
  logic [3*IW-1:0]       raddr, raddr_q, waddr;
  logic                  wr_ok;
  assign ta    = cmd.tap[1:0];
  assign tb    = cmd.tap[3:2];
  assign tc    = cmd.tap[5:4];
  assign raddr = {clamp_tap(cpos_r[2], tc, size_z), clamp_tap(cpos_r[1], tb, size_y),
                  clamp_tap(cpos_r[0], ta, size_x)};
  assign waddr = {IW'(cell_z), IW'(cell_y), IW'(cell_x)};
  assign wr_ok = (int'(cell_x) < MAX_DIM) && (int'(cell_y) < MAX_DIM) &&
                 (int'(cell_z) < MAX_DIM);

  // grid memory
  logic signed [SAMPLE_WIDTH-1:0] grid_mem [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rd_q;
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) grid_mem[waddr] <= sample_value;
    rd_q <= grid_mem[raddr_q];
  end

  // tap pipeline
  logic                           v1, v2, v3;
  logic signed [2*WW-1:0]         p1_q, p2_q;
  logic signed [WW-1:0]           wz1_q, wxy, wxyz;
  logic signed [WW+SAMPLE_WIDTH-1:0] p3_q;
  logic signed [TRW-1:0]          term;
  logic signed [AW-1:0]           acc;

  assign wxy  = WW'(p1_q >>> F);
  assign wxyz = WW'(p2_q >>> F);
  assign term = TRW'(p3_q >>> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.tap_issue;
      v2 <= v1;
      v3 <= v2;
    end
    raddr_q <= raddr;
    p1_q    <= wx[ta] * wy[tb];
    wz1_q   <= wz[tc];
    p2_q    <= wxy * wz1_q;
    p3_q    <= wxyz * rd_q;
    if (cmd.capture) acc <= '0;
    else if (v3)     acc <= acc + AW'(term);
  end

  assign sts.busy = v1 | v2 | v3;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (acc > SAT_HI) begin
        interp_value <= SAT_HI[SAMPLE_WIDTH-1:0];
        saturated    <= 1'b1;
      end else if (acc < SAT_LO) begin
        interp_value <= SAT_LO[SAMPLE_WIDTH-1:0];
        saturated    <= 1'b1;
      end else begin
        interp_value <= acc[SAMPLE_WIDTH-1:0];
        saturated    <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tricubic sampler controller
// Sequences split, weight and tap phases; owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tcr_ctrl import tcr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_operation,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SPLIT = 8'b0000_0010,
    S_SQ    = 8'b0000_0100,
    S_CUBE  = 8'b0000_1000,
    S_WGT   = 8'b0001_0000,
    S_TAPS  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [TAP_W-1:0]  cnt, cnt_next;
  logic [1:0]        axis, axis_next;
  logic              out_valid_next;
  logic              accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    axis_next      = axis;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.axis       = axis;
    cmd.tap        = cnt;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_QUERY) begin
            cmd.capture = 1'b1;
            cnt_next    = '0;
            state_next  = S_SPLIT;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      S_SPLIT: begin
        cmd.axis        = cnt[1:0];
        cmd.split_issue = (cnt != TAP_W'(3));
        cnt_next        = cnt + TAP_W'(1);
        if (cnt == TAP_W'(3)) begin
          axis_next  = 2'd0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube   = 1'b1;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.wgt = 1'b1;
        if (axis == 2'd2) begin
          cnt_next   = '0;
          state_next = S_TAPS;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_SQ;
        end
      end
      S_TAPS: begin
        cmd.tap_issue = 1'b1;
        cnt_next      = cnt + TAP_W'(1);
        if (cnt == '1) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tricubic_catmull_rom_sampler.sv @@
// ----------------------------------------------------------------------------
// Tricubic Catmull-Rom sampler: a write word is stored as it is accepted; a
// query word holds off further requests until its response is loaded, with
// the 64 taps read one per cycle from the single grid memory read port.
// Reset returns the config registers to defaults; the grid is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tricubic_catmull_rom_sampler import tcr_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tcr_req_if.sink               request,
  tcr_rsp_if.source             response
);
  cmd_t cmd;
  sts_t sts;

  tcr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (request.valid),
    .in_operation (request.operation),
    .in_ready     (request.ready),
    .out_valid    (response.valid),
    .out_ready    (response.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  tcr_datapath #(
    .MAX_DIM      (MAX_DIM),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_x       (request.cell_x),
    .cell_y       (request.cell_y),
    .cell_z       (request.cell_z),
    .sample_value (request.sample_value),
    .point_x      (request.point_x),
    .point_y      (request.point_y),
    .point_z      (request.point_z),
    .cmd          (cmd),
    .sts          (sts),
    .interp_value (response.interp_value),
    .saturated    (response.saturated)
  );
endmodule
`default_nettype wire

@@ hw/rtl/tcr_checker.sv @@
// ----------------------------------------------------------------------------
// Tricubic sampler port checker
// Port-level assertions, bound to the sampler top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tricubic_catmull_rom_sampler_assert.svh"
module tcr_checker import tcr_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    req_operation,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic [SAMPLE_WIDTH-1:0] rsp_value,
  input logic                    rsp_saturated
);
  logic req_acc;
  assign req_acc = req_valid && req_ready;

  `TCR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_saturated), "response word dropped or changed while stalled")
  `TCR_ASSERT_NEXT(a_write_no_rsp, clk, rst, req_acc && req_operation == OP_WRITE && !rsp_valid, !rsp_valid, "write word produced a response")
  `TCR_ASSERT_NEXT(a_query_busy, clk, rst, req_acc && req_operation == OP_QUERY, !req_ready, "request taken while a query is in flight")
  `TCR_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !rsp_valid && req_ready, "sampler not idle after reset")
  `TCR_ASSERT_NOW(a_sat_clip, clk, rst, rsp_valid && rsp_saturated, rsp_value == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} || rsp_value == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}, "saturated flag without a clipped value")
endmodule

bind tricubic_catmull_rom_sampler tcr_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tcr_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (request.valid),
  .req_ready     (request.ready),
  .req_operation (request.operation),
  .rsp_valid     (response.valid),
  .rsp_ready     (response.ready),
  .rsp_value     (response.interp_value),
  .rsp_saturated (response.saturated)
);
`default_nettype wire

@@ sim/tricubic_catmull_rom_sampler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricubic Catmull-Rom sampler testbench
// Loads both grid corners, then drives directed and random write and query
// words through several register settings. Each query result is checked
// against a bit-exact fixed-point interpolation predictor kept in step with
// the grid; random queries only touch samples already written.
// Random idling, a long response hold-off and a full drain are included.
// ----------------------------------------------------------------------------
module tricubic_catmull_rom_sampler_tb;
  import tcr_pkg::*;

  localparam int DIM = 32;
  localparam longint FMASK = 64'hFFFF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LOAD_SPAN = 8;
  localparam int QUERY_TRIES = 500;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } interp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tcr_req_if req_ch();
  tcr_rsp_if rsp_ch();

  tricubic_catmull_rom_sampler dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .request(req_ch), .response(rsp_ch)
  );

  always #4 clk = ~clk;

  // predictor state
  logic signed [31:0] grid_mem [0:DIM*DIM*DIM-1];
  bit                 written [0:DIM*DIM*DIM-1];
  logic [5:0]         size_x = 6'd32, size_y = 6'd32, size_z = 6'd32;
  logic signed [31:0] org_x = 0, org_y = 0, org_z = 0;
  logic [31:0]        inv_sp = 32'd65536;

  interp_t expected_interp [$];
  int  mismatches = 0;
  bit  no_idle = 1'b0;
  int  hold_cycles = 0;
  int  quiet_cycles = 0;

  function automatic void split_axis(input logic signed [31:0] p, input logic signed [31:0] o,
                                     output longint cell_pos, output longint frac);
    longint rel;
    bit [63:0] mag, prod, cm, t;
    rel = longint'(p) - longint'(o);
    mag = (rel < 0) ? -rel : rel;
    prod = mag * {32'd0, inv_sp};
    if (rel >= 0) begin
      cm = prod >> 32;
      frac = (prod >> 16) & FMASK;
      cell_pos = (cm > 36) ? 36 : cm;
    end else begin
      t = (prod >> 16) + ((prod & FMASK) != 0);
      frac = (65536 - (t & FMASK)) & FMASK;
      cm = (t >> 16) + ((t & FMASK) != 0);
      cell_pos = -((cm > 4) ? 4 : longint'(cm));
    end
  endfunction

  function automatic void cr_weights(input longint u, output longint w [4]);
    longint u2, u3;
    u2 = longint'((64'(u) * 64'(u)) >> 16);
    u3 = longint'((64'(u2) * 64'(u)) >> 16);
    w[0] = (-u3 + 2 * u2 - u) >>> 1;
    w[1] = (3 * u3 - 5 * u2 + 2 * 65536) >>> 1;
    w[2] = (-3 * u3 + 4 * u2 + u) >>> 1;
    w[3] = (u3 - u2) >>> 1;
  endfunction

  function automatic longint mul_q16(input longint a, input longint b);
    return a * (b >>> 16) + ((a * (b & FMASK)) >>> 16);
  endfunction

  function automatic longint used_size(input logic [5:0] n);
    if (n == 0) return 1;
    if (n > DIM) return DIM;
    return n;
  endfunction

  function automatic longint clamp_tap(input longint t, input longint n);
    if (t < 0) return 0;
    if (t >= n) return n - 1;
    return t;
  endfunction

  function automatic interp_t interp_predict(input logic signed [31:0] px, py, pz);
    longint cx, cy, cz, fx, fy, fz, nx, ny, nz, sum, p, q, r, wxyz;
    longint wx [4], wy [4], wz [4];
    interp_t res;
    split_axis(px, org_x, cx, fx);
    split_axis(py, org_y, cy, fy);
    split_axis(pz, org_z, cz, fz);
    cr_weights(fx, wx);
    cr_weights(fy, wy);
    cr_weights(fz, wz);
    nx = used_size(size_x);
    ny = used_size(size_y);
    nz = used_size(size_z);
    sum = 0;
    for (int c = 0; c < 4; c++) begin
      r = clamp_tap(cz + c - 1, nz);
      for (int b = 0; b < 4; b++) begin
        q = clamp_tap(cy + b - 1, ny);
        for (int a = 0; a < 4; a++) begin
          p = clamp_tap(cx + a - 1, nx);
          wxyz = mul_q16(mul_q16(wx[a], wy[b]), wz[c]);
          sum += mul_q16(wxyz, longint'(grid_mem[p + DIM * (q + DIM * r)]));
        end
      end
    end
    res.sat = 1'b1;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    else res.sat = 1'b0;
    res.value = sum[31:0];
    return res;
  endfunction

  // true when all 64 taps of the point hit written samples
  function automatic bit taps_written(input logic signed [31:0] px, py, pz);
    longint cx, cy, cz, fx, fy, fz, nx, ny, nz, p, q, r;
    split_axis(px, org_x, cx, fx);
    split_axis(py, org_y, cy, fy);
    split_axis(pz, org_z, cz, fz);
    nx = used_size(size_x);
    ny = used_size(size_y);
    nz = used_size(size_z);
    for (int c = 0; c < 4; c++) begin
      r = clamp_tap(cz + c - 1, nz);
      for (int b = 0; b < 4; b++) begin
        q = clamp_tap(cy + b - 1, ny);
        for (int a = 0; a < 4; a++) begin
          p = clamp_tap(cx + a - 1, nx);
          if (!written[p + DIM * (q + DIM * r)]) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // one word on the request channel; prediction at the accepting edge
  task automatic send_word(input logic op, input logic [4:0] x, y, z,
                           input logic signed [31:0] sv, px, py, pz);
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.operation = op;
    req_ch.cell_x = x;
    req_ch.cell_y = y;
    req_ch.cell_z = z;
    req_ch.sample_value = sv;
    req_ch.point_x = px;
    req_ch.point_y = py;
    req_ch.point_z = pz;
    do @(posedge clk); while (!req_ch.ready);
    if (op == OP_WRITE) begin
      grid_mem[x + DIM * (y + DIM * z)] = sv;
      written[x + DIM * (y + DIM * z)] = 1'b1;
    end else begin
      expected_interp = {expected_interp, interp_predict(px, py, pz)};
    end
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end
  endtask

  task automatic write_sample(input logic [4:0] x, y, z, input logic signed [31:0] sv);
    send_word(OP_WRITE, x, y, z, sv, $urandom, $urandom, $urandom);
  endtask

  task automatic query_point(input logic signed [31:0] px, py, pz);
    send_word(OP_QUERY, $urandom, $urandom, $urandom, $urandom, px, py, pz);
  endtask

  function automatic logic signed [31:0] rand_coord(input logic signed [31:0] o);
    if ($urandom_range(0, 3) != 0)
      return o + $signed($urandom_range(0, 38 << 16)) - (3 << 16);
    return $urandom;
  endfunction

  // random point over written samples; the origin maps to cell 0 otherwise
  task automatic random_query();
    logic signed [31:0] px, py, pz;
    int tries;
    tries = 0;
    do begin
      px = rand_coord(org_x);
      py = rand_coord(org_y);
      pz = rand_coord(org_z);
      tries++;
    end while (!taps_written(px, py, pz) && tries < QUERY_TRIES);
    if (!taps_written(px, py, pz)) begin
      px = org_x;
      py = org_y;
      pz = org_z;
    end
    query_point(px, py, pz);
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  // low indexes 0..4, high indexes 29..31
  function automatic logic [4:0] load_coord(input int k);
    return (k < 5) ? 5'(k) : 5'(k + 24);
  endfunction

  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (expected_interp.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      CFG_GRID_X:   size_x = val[5:0];
      CFG_GRID_Y:   size_y = val[5:0];
      CFG_GRID_Z:   size_z = val[5:0];
      CFG_ORIGIN_X: org_x = val;
      CFG_ORIGIN_Y: org_y = val;
      CFG_ORIGIN_Z: org_z = val;
      CFG_INV_SP:   inv_sp = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_all(input logic [5:0] sx, sy, sz, input logic [31:0] ox, oy, oz, isp);
    drain();
    set_reg(CFG_GRID_X, sx);
    set_reg(CFG_GRID_Y, sy);
    set_reg(CFG_GRID_Z, sz);
    set_reg(CFG_ORIGIN_X, ox);
    set_reg(CFG_ORIGIN_Y, oy);
    set_reg(CFG_ORIGIN_Z, oz);
    set_reg(CFG_INV_SP, isp);
  endtask

  task automatic random_words(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3)
        write_sample($urandom, $urandom, $urandom, rand_sample());
      else
        random_query();
    end
  endtask

  // both grid corners written before any query
  task automatic test_load_grid();
    no_idle = 1'b1;
    for (int i = 0; i < LOAD_SPAN * LOAD_SPAN * LOAD_SPAN; i++)
      write_sample(load_coord(i % LOAD_SPAN), load_coord((i / LOAD_SPAN) % LOAD_SPAN),
                   load_coord(i / (LOAD_SPAN * LOAD_SPAN)), rand_sample());
    no_idle = 1'b0;
  endtask

  task automatic test_directed();
    query_point(0, 0, 0);
    query_point(32'sh0001_8000, 32'sh0002_FFFF, 32'sh0002_0001);
    query_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh001F_0000);
    query_point(32'shFFFF_FFFF, 32'shFFFF_0000, 32'shFFFD_8000);
    query_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_FFFF);
    // overshooting neighborhoods, both signs
    for (int z = 8; z < 12; z++)
      for (int y = 8; y < 12; y++) begin
        write_sample(7, y, z, 32'sh8000_0000);
        write_sample(8, y, z, 32'sh7FFF_FFFF);
        write_sample(9, y, z, 32'sh7FFF_FFFF);
        write_sample(10, y, z, 32'sh8000_0000);
        write_sample(19, y, z, 32'sh7FFF_FFFF);
        write_sample(20, y, z, 32'sh8000_0000);
        write_sample(21, y, z, 32'sh8000_0000);
        write_sample(22, y, z, 32'sh7FFF_FFFF);
      end
    query_point(32'sh0008_8000, 32'sh0009_0000, 32'sh0009_0000);
    query_point(32'sh0014_8000, 32'sh0009_0000, 32'sh0009_0000);
    query_point(32'sh0014_0000, 32'sh0009_0000, 32'sh0009_0000);
    write_sample(31, 31, 31, 32'sh0001_0000);
    write_sample(0, 0, 0, 32'sh8000_0001);
    query_point(32'sh001F_0000, 32'sh001F_0000, 32'sh001F_0000);
  endtask

  task automatic test_config_sweep();
    set_all(6'd1, 6'd1, 6'd1, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'hFFFF_FFFF);
    random_words(30);
    set_all(6'd0, 6'd63, 6'd33, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFF0_0000, 32'd0);
    random_words(30);
    set_all(6'd4, 6'd5, 6'd32, 32'shFFFE_8000, 32'sh0003_0000, 32'sh0000_0001, 32'd1);
    random_words(30);
    set_all(6'd32, 6'd32, 6'd32, 32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_0000, 32'h0002_0000);
    random_words(30);
    set_all($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
            $urandom, $urandom, $urandom, $urandom_range(16384, 262144));
    random_words(40);
    set_all(6'd32, 6'd32, 6'd32, 32'sh0, 32'sh0, 32'sh0, 32'd65536);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      random_query();
  endtask

  task automatic test_random();
    random_words(100);
    drain();
    random_words(80);
    set_all($urandom_range(2, 32), $urandom_range(2, 32), $urandom_range(2, 32),
            32'sh0, 32'sh0, 32'sh0, $urandom_range(40000, 100000));
    random_words(50);
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    random_words(100);
  endtask

  // response side: random stalls plus an optional long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        hold_cycles--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    interp_t exp_w;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_interp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value=%0d sat=%0b", rsp_ch.interp_value, rsp_ch.saturated);
      end else begin
        exp_w = expected_interp.pop_front();
        if (rsp_ch.interp_value !== exp_w.value || rsp_ch.saturated !== exp_w.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                     exp_w.value, exp_w.sat, rsp_ch.interp_value, rsp_ch.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = OP_WRITE;
    req_ch.cell_x = '0;
    req_ch.cell_y = '0;
    req_ch.cell_z = '0;
    req_ch.sample_value = '0;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.point_z = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_load_grid();
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    test_no_idle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (expected_interp.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tcr_pkg.sv
hw/rtl/tcr_req_if.sv
hw/rtl/tcr_datapath.sv
hw/rtl/tcr_ctrl.sv
hw/rtl/tricubic_catmull_rom_sampler.sv
hw/rtl/tcr_checker.sv
sim/tricubic_catmull_rom_sampler_tb.sv
